// ===== sv/quadratic_bezier_plotter_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quadratic Bezier plotter
// Clocked checks on clk; the reset-qualified form is held off while rst_n is
// low. Empty bodies when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_BEZIER_PLOTTER_MACROS_SVH
`define QUADRATIC_BEZIER_PLOTTER_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every rising edge outside reset
`define QBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check a property on every rising edge, reset included
`define QBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define QBP_ASSERT(label, prop, msg)
`define QBP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== sv/qbp_pkg.sv =====
// ---------------------------------------------------------------------------
// qbp_pkg
// Shared widths, register codes and inter-module types of the plotter.
// ---------------------------------------------------------------------------
`default_nettype none

package qbp_pkg;

    // default number of steps along the curve; STEPS must be a power of two
    localparam int QBP_STEPS_DEFAULT = 1024;

    // field widths
    localparam int QBP_COORD_W = 12;
    localparam int QBP_COLOR_W = 4;

    // configuration port
    localparam int QBP_ADDR_W  = 5;
    localparam int QBP_DATA_W  = 32;
    localparam logic [QBP_COLOR_W-1:0] QBP_COLOR_RESET = 4'hF;

    // depth of the queue between front and back
    localparam int QBP_QUEUE_DEPTH = 2;

    // register indexes
    typedef enum logic [2:0] {
        REG_P0_X       = 3'd0,
        REG_P0_Y       = 3'd1,
        REG_P1_X       = 3'd2,
        REG_P1_Y       = 3'd3,
        REG_P2_X       = 3'd4,
        REG_P2_Y       = 3'd5,
        REG_DRAW_COLOR = 3'd6
    } qbp_reg_t;

    // per-pixel tag carried alongside the step index
    typedef struct packed {
        logic                   last;
        logic [QBP_COLOR_W-1:0] color;
    } qbp_tag_t;

    localparam int QBP_TAG_W = $bits(qbp_tag_t);

endpackage

`default_nettype wire

// ===== sv/qbp_fifo.sv =====
// ---------------------------------------------------------------------------
// qbp_fifo
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none
`include "quadratic_bezier_plotter_macros.svh"

module qbp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         valid
);
    import qbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the incoming transfer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `QBP_ASSERT(a_fifo_no_overflow, push |-> (count_reg != CNT_W'(DEPTH)), "queue push while full")

endmodule

`default_nettype wire

// ===== sv/qbp_front.sv =====
// ---------------------------------------------------------------------------
// qbp_front
// Takes tick transfers, keeps the step counter and queues the step index
// with its end-of-curve flag and colour.
// ---------------------------------------------------------------------------
`default_nettype none
`include "quadratic_bezier_plotter_macros.svh"

module qbp_front #(
    parameter  int STEPS = 1024,
    localparam int K_W   = $clog2(STEPS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            restart,
    output logic                            full,
    input  logic [qbp_pkg::QBP_COLOR_W-1:0] color,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [K_W-1:0]                  q_k,
    output qbp_pkg::qbp_tag_t               q_tag
);
    import qbp_pkg::*;

    logic [K_W-1:0] step_reg, step_next;
    logic [K_W-1:0] k_cur;
    logic           last_cur;

    assign full   = q_full;
    assign q_push = push && !q_full;

    // pick the step for this tick and the one after it
    always_comb
    begin
        k_cur     = restart ? '0 : step_reg;
        last_cur  = (k_cur == K_W'(STEPS));
        step_next = step_reg;
        if (q_push)
        begin
            step_next = last_cur ? '0 : k_cur + 1'b1;
        end
    end

    assign q_k         = k_cur;
    assign q_tag.last  = last_cur;
    assign q_tag.color = color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    `QBP_ASSERT_ALWAYS(a_step_range, step_reg <= K_W'(STEPS), "step counter beyond end of curve")
    `QBP_ASSERT(a_wrap_after_last, (q_push && last_cur) |=> (step_reg == '0), "no wrap after last")

endmodule

`default_nettype wire

// ===== sv/qbp_div.sv =====
// ---------------------------------------------------------------------------
// qbp_div
// Rounding stage: divides a weighted sum by STEPS^2, rounded half up. STEPS is
// a power of two, so this is a rounding add and a shift, registered once.
// ---------------------------------------------------------------------------
`default_nettype none

module qbp_div #(
    parameter  int STEPS = 1024,
    localparam int K_W   = $clog2(STEPS + 1),
    localparam int NUM_W = 2 * K_W + qbp_pkg::QBP_COORD_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NUM_W-1:0]                num,
    output logic                            done,
    output logic [qbp_pkg::QBP_COORD_W-1:0] quot
);
    import qbp_pkg::*;

    localparam int SUM_W = NUM_W + 1;
    localparam int SQ_SH = 2 * $clog2(STEPS);
    localparam longint unsigned HALF = 64'd1 << (SQ_SH - 1);

    logic [SUM_W-1:0]       sum;
    logic [QBP_COORD_W-1:0] q_reg, q_next;
    logic                   done_reg;

    // add half of STEPS^2, then drop the fraction bits
    assign sum    = {1'b0, num} + SUM_W'(HALF);
    assign q_next = start ? sum[SQ_SH +: QBP_COORD_W] : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // hold the quotient until the next start
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== sv/qbp_back.sv =====
// ---------------------------------------------------------------------------
// qbp_back
// Evaluates the curve point for a queued step: weight products, weighted
// sums, rounding shift, then the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "quadratic_bezier_plotter_macros.svh"

module qbp_back #(
    parameter  int STEPS = 1024,
    localparam int K_W   = $clog2(STEPS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [K_W-1:0]                  q_k,
    input  qbp_pkg::qbp_tag_t               q_tag,
    output logic                            q_pop,
    input  logic [qbp_pkg::QBP_COORD_W-1:0] p0_x,
    input  logic [qbp_pkg::QBP_COORD_W-1:0] p0_y,
    input  logic [qbp_pkg::QBP_COORD_W-1:0] p1_x,
    input  logic [qbp_pkg::QBP_COORD_W-1:0] p1_y,
    input  logic [qbp_pkg::QBP_COORD_W-1:0] p2_x,
    input  logic [qbp_pkg::QBP_COORD_W-1:0] p2_y,
    input  logic                            pop,
    output logic                            empty,
    output logic [qbp_pkg::QBP_COORD_W-1:0] pixel_x,
    output logic [qbp_pkg::QBP_COORD_W-1:0] pixel_y,
    output logic [qbp_pkg::QBP_COLOR_W-1:0] pixel_color,
    output logic                            last_point
);
    import qbp_pkg::*;

    localparam int SQ_W  = 2 * K_W;
    localparam int NUM_W = SQ_W + QBP_COORD_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL1  = 7'b0000010,
        S_MUL2  = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [K_W-1:0]   k_reg;
    qbp_tag_t         tag_reg;
    logic [K_W-1:0]   u_cur;
    logic [SQ_W-1:0]  uu_reg, uk_reg, kk_reg;
    logic [NUM_W-1:0] ax_reg, bx_reg, cx_reg;
    logic [NUM_W-1:0] ay_reg, by_reg, cy_reg;
    logic [NUM_W-1:0] num_x_reg, num_y_reg;

    logic                   div_start;
    logic                   x_done, y_done;
    logic [QBP_COORD_W-1:0] x_quot, y_quot;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;
    logic [QBP_COORD_W-1:0] px_reg, py_reg;
    qbp_tag_t               otag_reg;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign div_start = (state_reg == S_START);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || pop);
    assign u_cur     = K_W'(STEPS) - k_reg;

    // sequence one item through the datapath
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_SUM;
            S_SUM:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (x_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold a finished pixel until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            k_reg   <= q_k;
            tag_reg <= q_tag;
        end
        if (state_reg == S_MUL1)
        begin
            uu_reg <= SQ_W'(u_cur) * SQ_W'(u_cur);
            uk_reg <= SQ_W'(u_cur) * SQ_W'(k_reg);
            kk_reg <= SQ_W'(k_reg) * SQ_W'(k_reg);
        end
        if (state_reg == S_MUL2)
        begin
            ax_reg <= NUM_W'(uu_reg) * NUM_W'(p0_x);
            bx_reg <= NUM_W'(uk_reg) * NUM_W'(p1_x);
            cx_reg <= NUM_W'(kk_reg) * NUM_W'(p2_x);
            ay_reg <= NUM_W'(uu_reg) * NUM_W'(p0_y);
            by_reg <= NUM_W'(uk_reg) * NUM_W'(p1_y);
            cy_reg <= NUM_W'(kk_reg) * NUM_W'(p2_y);
        end
        if (state_reg == S_SUM)
        begin
            num_x_reg <= ax_reg + (bx_reg << 1) + cx_reg;
            num_y_reg <= ay_reg + (by_reg << 1) + cy_reg;
        end
        if (out_load)
        begin
            px_reg   <= x_quot;
            py_reg   <= y_quot;
            otag_reg <= tag_reg;
        end
    end

    qbp_div #(
        .STEPS (STEPS)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_x_reg),
        .done  (x_done),
        .quot  (x_quot)
    );

    qbp_div #(
        .STEPS (STEPS)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_y_reg),
        .done  (y_done),
        .quot  (y_quot)
    );

    assign empty       = !out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = otag_reg.color;
    assign last_point  = otag_reg.last;

    `QBP_ASSERT(a_div_lockstep, x_done == y_done, "x and y rounding stages out of step")
    `QBP_ASSERT(a_div_done_in_wait, x_done |-> (state_reg == S_DIV), "rounding done out of turn")

endmodule

`default_nettype wire

// ===== sv/quadratic_bezier_plotter.sv =====
// ---------------------------------------------------------------------------
// quadratic_bezier_plotter
// Plots a quadratic Bezier curve from three control points, one pixel per
// tick, rounded half up, with the configured colour.
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------------
//   tick      push / full            restart
//   pixel     empty / pop            pixel_x, pixel_y, pixel_color, last_point
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A pixel passes from its taken tick to the result ports through queue
// read, weights, products, sums, rounding shift, done, output register.
// The back end works on one pixel at a time; it takes none while it is busy.
// A waiting pixel lets the back end finish the next one, which then holds
// until pop; the two-entry queue then fills and raises full.
// Reset clears step counter, queue, sequencer, points; sets colour; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module quadratic_bezier_plotter #(
    parameter int STEPS = qbp_pkg::QBP_STEPS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qbp_pkg::QBP_ADDR_W-1:0]  paddr,
    input  logic [qbp_pkg::QBP_DATA_W-1:0]  pwdata,
    output logic [qbp_pkg::QBP_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic                            restart,
    output logic                            empty,
    input  logic                            pop,
    output logic [qbp_pkg::QBP_COORD_W-1:0] pixel_x,
    output logic [qbp_pkg::QBP_COORD_W-1:0] pixel_y,
    output logic [qbp_pkg::QBP_COLOR_W-1:0] pixel_color,
    output logic                            last_point
);
    import qbp_pkg::*;

    localparam int K_W   = $clog2(STEPS + 1);
    localparam int ITEM_W = K_W + QBP_TAG_W;

    logic [QBP_COORD_W-1:0] p0_x_reg, p0_y_reg, p1_x_reg, p1_y_reg, p2_x_reg, p2_y_reg;
    logic [QBP_COLOR_W-1:0] color_reg;
    logic                   cfg_write;
    qbp_reg_t               cfg_idx;

    logic                   q_full, q_push, q_pop, q_valid;
    logic [K_W-1:0]         f_k, b_k;
    qbp_tag_t               f_tag, b_tag;
    logic [ITEM_W-1:0]      q_rdata;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = qbp_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_x_reg  <= '0;
            p0_y_reg  <= '0;
            p1_x_reg  <= '0;
            p1_y_reg  <= '0;
            p2_x_reg  <= '0;
            p2_y_reg  <= '0;
            color_reg <= QBP_COLOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_P0_X:       p0_x_reg  <= pwdata[QBP_COORD_W-1:0];
                REG_P0_Y:       p0_y_reg  <= pwdata[QBP_COORD_W-1:0];
                REG_P1_X:       p1_x_reg  <= pwdata[QBP_COORD_W-1:0];
                REG_P1_Y:       p1_y_reg  <= pwdata[QBP_COORD_W-1:0];
                REG_P2_X:       p2_x_reg  <= pwdata[QBP_COORD_W-1:0];
                REG_P2_Y:       p2_y_reg  <= pwdata[QBP_COORD_W-1:0];
                REG_DRAW_COLOR: color_reg <= pwdata[QBP_COLOR_W-1:0];
                default:        ;
            endcase
        end
    end

    // read back the addressed register
    always_comb
    begin
        case (cfg_idx)
            REG_P0_X:       prdata = QBP_DATA_W'(p0_x_reg);
            REG_P0_Y:       prdata = QBP_DATA_W'(p0_y_reg);
            REG_P1_X:       prdata = QBP_DATA_W'(p1_x_reg);
            REG_P1_Y:       prdata = QBP_DATA_W'(p1_y_reg);
            REG_P2_X:       prdata = QBP_DATA_W'(p2_x_reg);
            REG_P2_Y:       prdata = QBP_DATA_W'(p2_y_reg);
            REG_DRAW_COLOR: prdata = QBP_DATA_W'(color_reg);
            default:        prdata = '0;
        endcase
    end

    qbp_front #(
        .STEPS (STEPS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .restart (restart),
        .full    (full),
        .color   (color_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_k     (f_k),
        .q_tag   (f_tag)
    );

    qbp_fifo #(
        .W     (ITEM_W),
        .DEPTH (QBP_QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_k, f_tag}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    assign b_k   = q_rdata[ITEM_W-1:QBP_TAG_W];
    assign b_tag = qbp_tag_t'(q_rdata[QBP_TAG_W-1:0]);

    qbp_back #(
        .STEPS (STEPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_k         (b_k),
        .q_tag       (b_tag),
        .q_pop       (q_pop),
        .p0_x        (p0_x_reg),
        .p0_y        (p0_y_reg),
        .p1_x        (p1_x_reg),
        .p1_y        (p1_y_reg),
        .p2_x        (p2_x_reg),
        .p2_y        (p2_y_reg),
        .pop         (pop),
        .empty       (empty),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_point  (last_point)
    );

endmodule

`default_nettype wire
